// ===== rtl/core/tmd_pkg.sv =====
// shared types, constants and codes of the typed message deframer
package tmd_pkg;

  // table geometry
  localparam int NUM_TYPES = 256;
  localparam int TYPE_AW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  // field widths
  localparam int BYTE_W = 8;
  localparam int CODE_W = 17;
  localparam int LEN_W  = 16;
  localparam int STAT_W = 3;

  // stream bus widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // special length codes
  localparam logic [CODE_W-1:0] CODE_UNBOUND  = '0;
  localparam logic [CODE_W-1:0] CODE_BYTE_LEN = '1;
  localparam logic [CODE_W-1:0] CODE_WORD_LEN = {{(CODE_W-1){1'b1}}, 1'b0};

  // header sizes of the length forms
  localparam logic [LEN_W-1:0] HDR_FIXED = 16'd1;
  localparam logic [LEN_W-1:0] HDR_BYTE  = 16'd2;
  localparam logic [LEN_W-1:0] HDR_WORD  = 16'd3;

  // request kinds
  typedef enum logic {
    OP_DEFINE = 1'b0,
    OP_BYTE   = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_INCOMPLETE = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_UNBOUND    = 3'd2,
    ST_BADLEN     = 3'd3,
    ST_DEFINED    = 3'd4
  } status_e;

  // parser phases
  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  // table access from the input stage
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [BYTE_W-1:0] wr_idx;
    logic [CODE_W-1:0] wr_code;
    logic [BYTE_W-1:0] rd_idx;
  } tbl_req_t;

  // one result of the parser
  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] msg_type;
    logic [LEN_W-1:0]  msg_len;
  } result_t;

endpackage

// ===== rtl/core/typed_message_deframer.sv =====
// top level of the typed message deframer
//
// Input stream: each request is either a definition (tuser = 0) that stores
// the length code of one message type, or a stream byte (tuser = 1) fed to
// the message parser. Every request yields exactly one result on the output
// stream: its status in tuser, the current message type and, on completion,
// the total message length in tdata.
// A request accepted is held in the parse stage, and its result is then
// registered in the output register. Throughput is one request per cycle
// unless the receiver stalls: the table read is issued at acceptance from a
// 256-entry synchronous ram and its registered data is consumed by the parser
// in the following stage, so a stream byte and a preceding definition never
// touch the ram in the same cycle.
// Reset clears the valid bit of every table entry at once (all types
// unbound) and returns the parser to waiting for a type byte; no clearing
// pass is needed, requests are taken from the first cycle after reset.
// When the receiver stalls, the result waits in the output register, the
// parse stage holds one more request, and tready drops only when both are
// full.
module typed_message_deframer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // type_id [7:0], length_code [24:8], data_byte [32:25], zero [39:33]
  input  logic [tmd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // operation [0]
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // message_type [7:0], message_length [23:8]
  output logic [tmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // status [2:0]
  output logic [tmd_pkg::STAT_W-1:0]          m_axis_tuser_o
);

  import tmd_pkg::*;

  logic              accept;
  logic              advance;
  logic              step;
  logic              s1_valid_q, s1_valid_d;
  op_e               s1_op_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  result_t           result;
  tbl_req_t          tbl_req;
  logic [CODE_W-1:0] code;
  op_e               in_op;
  logic [BYTE_W-1:0] in_type_id;
  logic [CODE_W-1:0] in_code;
  logic [BYTE_W-1:0] in_byte;

  // input field unpacking
  assign in_op      = op_e'(s_axis_tuser_i);
  assign in_type_id = s_axis_tdata_i[7:0];
  assign in_code    = s_axis_tdata_i[24:8];
  assign in_byte    = s_axis_tdata_i[32:25];

  // handshake control
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = s1_valid_q && advance;
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // table request issued at acceptance
  always_comb begin
    tbl_req.wr      = accept && (in_op == OP_DEFINE);
    tbl_req.rd      = accept && (in_op == OP_BYTE);
    tbl_req.wr_idx  = in_type_id;
    tbl_req.wr_code = in_code;
    tbl_req.rd_idx  = in_byte;
  end

  tmd_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .code_o (code)
  );

  tmd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .op_i     (s1_op_q),
    .byte_i   (s1_byte_q),
    .code_i   (code),
    .result_o (result)
  );

  // stage valid flags
  always_comb begin
    s1_valid_d = accept ? 1'b1 : (step ? 1'b0 : s1_valid_q);
    out_valid_d = step ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // parse stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= in_op;
      s1_byte_q <= in_byte;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.msg_len, out_q.msg_type};
  assign m_axis_tuser_o  = out_q.status;

endmodule

// ===== rtl/core/tmd_ram.sv =====
// generic single write port ram with registered read
module tmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/tmd_table.sv =====
// length code table: ram plus per-entry valid bits cleared at reset
module tmd_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tmd_pkg::tbl_req_t              req_i,
  output logic [tmd_pkg::CODE_W-1:0]     code_o
);

  import tmd_pkg::*;

  logic [NUM_TYPES-1:0] vld_q;
  logic                 hit_q;
  logic                 wr_in_range;
  logic                 rd_in_range;
  logic [TYPE_AW-1:0]   wr_addr;
  logic [TYPE_AW-1:0]   rd_addr;
  logic                 wr_en;
  logic [CODE_W-1:0]    rd_code;

  // index range checks and addresses
  assign wr_in_range = ({1'b0, req_i.wr_idx} < (BYTE_W+1)'(NUM_TYPES));
  assign rd_in_range = ({1'b0, req_i.rd_idx} < (BYTE_W+1)'(NUM_TYPES));
  assign wr_addr     = req_i.wr_idx[TYPE_AW-1:0];
  assign rd_addr     = req_i.rd_idx[TYPE_AW-1:0];
  assign wr_en       = req_i.wr && wr_in_range;

  tmd_ram #(
    .WIDTH (CODE_W),
    .DEPTH (NUM_TYPES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (req_i.wr_code),
    .rd_en_i   (req_i.rd),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_code)
  );

  // valid bits, an entry never written reads as unbound
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // hit flag travels with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (req_i.rd) begin
      hit_q <= rd_in_range && vld_q[rd_addr];
    end
  end

  assign code_o = hit_q ? rd_code : CODE_UNBOUND;

  // a stored definition marks its entry valid
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> vld_q[$past(wr_addr)])
    else $error("table write did not set the valid bit");

endmodule

// ===== rtl/core/tmd_parser.sv =====
// message parser state and result logic, one request per step
module tmd_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  tmd_pkg::op_e                   op_i,
  input  logic [tmd_pkg::BYTE_W-1:0]     byte_i,
  input  logic [tmd_pkg::CODE_W-1:0]     code_i,
  output tmd_pkg::result_t               result_o
);

  import tmd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [BYTE_W-1:0]  type_q, type_d;
  logic [LEN_W-1:0]   exp_q, exp_d;
  logic [LEN_W-1:0]   rcv_q, rcv_d;
  logic               fin;
  logic [LEN_W-1:0]   fin_total;
  logic [LEN_W-1:0]   fin_hdr;
  logic [LEN_W-1:0]   body_cnt;

  assign body_cnt = rcv_q + 16'd1;

  // next state and result
  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    exp_d     = exp_q;
    rcv_d     = rcv_q;
    fin       = 1'b0;
    fin_total = '0;
    fin_hdr   = HDR_FIXED;
    result_o.status  = ST_DEFINED;
    result_o.msg_len = '0;
    if (op_i == OP_BYTE) begin
      result_o.status = ST_INCOMPLETE;
      case (phase_q)
        PH_TYPE: begin
          type_d = byte_i;
          rcv_d  = 16'd1;
          if (code_i == CODE_UNBOUND) begin
            result_o.status = ST_UNBOUND;
          end else if (!code_i[CODE_W-1]) begin
            fin       = 1'b1;
            fin_total = code_i[LEN_W-1:0];
            fin_hdr   = HDR_FIXED;
          end else if (code_i == CODE_BYTE_LEN) begin
            exp_d   = HDR_BYTE;
            phase_d = PH_LEN_LO;
          end else if (code_i == CODE_WORD_LEN) begin
            exp_d   = HDR_WORD;
            phase_d = PH_LEN_LO;
          end else begin
            result_o.status = ST_BADLEN;
          end
        end
        PH_LEN_LO: begin
          rcv_d = 16'd2;
          if (exp_q == HDR_BYTE) begin
            fin       = 1'b1;
            fin_total = {8'd0, byte_i};
            fin_hdr   = HDR_BYTE;
          end else begin
            exp_d   = {8'd0, byte_i};
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          rcv_d     = 16'd3;
          fin       = 1'b1;
          fin_total = {byte_i, exp_q[BYTE_W-1:0]};
          fin_hdr   = HDR_WORD;
        end
        PH_BODY: begin
          rcv_d = body_cnt;
          if (body_cnt >= exp_q) begin
            result_o.status  = ST_COMPLETE;
            result_o.msg_len = exp_q;
            phase_d          = PH_TYPE;
          end
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase
      // declared length against its header
      if (fin) begin
        if (fin_total < fin_hdr) begin
          result_o.status = ST_BADLEN;
          phase_d         = PH_TYPE;
        end else if (fin_total == fin_hdr) begin
          result_o.status  = ST_COMPLETE;
          result_o.msg_len = fin_total;
          phase_d          = PH_TYPE;
        end else begin
          exp_d   = fin_total;
          phase_d = PH_BODY;
        end
      end
    end
    result_o.msg_type = type_d;
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= '0;
      exp_q   <= '0;
      rcv_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      exp_q   <= exp_d;
      rcv_q   <= rcv_d;
    end
  end

  // inside a body the count stays below the total
  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (rcv_q < exp_q))
    else $error("body byte count reached total without completion");

  // length is reported exactly on completion
  a_len_on_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> ((result_o.status == ST_COMPLETE) == (result_o.msg_len != '0)))
    else $error("message length disagrees with completion status");

  // the high length byte always follows the low one
  a_len_hi_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN_HI) |->
      ($past(phase_q) == PH_LEN_LO || $past(phase_q) == PH_LEN_HI))
    else $error("high length phase entered out of order");

endmodule
